// ===== hdl/qot_pkg.sv =====
// Shared widths and rounding constants for the quaternion offset transform.
package qot_pkg;

  localparam int unsigned QW = 16;
  localparam int unsigned CW = 32;
  localparam int unsigned SW = 31;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int RND_HALF = 1 << (FRAC_SHIFT - 1);

  // Local vector component: 32 bits plus one for the negated forward value.
  localparam int unsigned VW = CW + 1;
  // First cross product terms and their doubled, rounded difference.
  localparam int unsigned P1W = QW + VW;
  localparam int unsigned S1W = P1W + 2;
  localparam int unsigned TW = S1W - FRAC_SHIFT;
  // Second stage terms and their rounded sum.
  localparam int unsigned P2W = QW + TW;
  localparam int unsigned S2W = P2W + 2;
  localparam int unsigned RW = S2W - FRAC_SHIFT;
  // Origin plus local vector, and the final unsaturated position.
  localparam int unsigned OW = VW + 1;
  localparam int unsigned FW = RW + 1;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned NUM_STAGES = 5;

  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [P1W-1:0] prod1_t;
  typedef logic signed [TW-1:0] tvec_t;
  typedef logic signed [P2W-1:0] prod2_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic signed [OW-1:0] base_t;

endpackage

// ===== hdl/quaternion_offset_transform.sv =====
// Each accepted input beat is registered in every stage in turn.
// Throughput: one beat per cycle while the output is ready; each stage holds
// under back-pressure and empty stages collapse, so a stalled output still
// lets new beats fill bubbles. Stages: two exact multiplies, two round-and-shift
// steps and a final add with saturation. Reset clears only the stage valid bits.
module quaternion_offset_transform
  import qot_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   quat_x_i,
  input  logic signed [15:0]   quat_y_i,
  input  logic signed [15:0]   quat_z_i,
  input  logic signed [15:0]   quat_w_i,
  input  logic signed [31:0]   origin_x_i,
  input  logic signed [31:0]   origin_y_i,
  input  logic signed [31:0]   origin_z_i,
  input  logic signed [31:0]   offset_right_i,
  input  logic signed [31:0]   offset_up_i,
  input  logic signed [31:0]   offset_forward_i,
  input  logic        [30:0]   quad_size_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   pos_x_o,
  output logic signed [31:0]   pos_y_o,
  output logic signed [31:0]   pos_z_o,
  output logic        [30:0]   quad_size_out_o
);

  // Stage valid bits and load enables.
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] en;

  assign en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
  for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  // Input operands, indexed by axis; index three of the quaternion is w.
  quat_t q_in [4];
  vec_t  v_in [NUM_AXES];
  logic signed [CW-1:0] o_in [NUM_AXES];

  assign q_in[0] = quat_x_i;
  assign q_in[1] = quat_y_i;
  assign q_in[2] = quat_z_i;
  assign q_in[3] = quat_w_i;
  assign v_in[0] = VW'(offset_right_i);
  assign v_in[1] = VW'(offset_up_i);
  // Forward points into the screen, so local z is its negation; one extra
  // bit keeps the most negative input exact.
  assign v_in[2] = vec_t'(0) - VW'(offset_forward_i);
  assign o_in[0] = origin_x_i;
  assign o_in[1] = origin_y_i;
  assign o_in[2] = origin_z_i;

  // Stage registers.
  prod1_t p1a_q [NUM_AXES];
  prod1_t p1b_q [NUM_AXES];
  quat_t  q1_q  [4];
  base_t  ov1_q [NUM_AXES];
  logic [SW-1:0] sz1_q;

  tvec_t  t2_q  [NUM_AXES];
  quat_t  q2_q  [4];
  base_t  ov2_q [NUM_AXES];
  logic [SW-1:0] sz2_q;

  prod2_t wt3_q [NUM_AXES];
  prod2_t ca3_q [NUM_AXES];
  prod2_t cb3_q [NUM_AXES];
  base_t  ov3_q [NUM_AXES];
  logic [SW-1:0] sz3_q;

  rot_t   r4_q  [NUM_AXES];
  base_t  ov4_q [NUM_AXES];
  logic [SW-1:0] sz4_q;

  logic signed [CW-1:0] pos_q [NUM_AXES];
  logic [SW-1:0] sz5_q;

  prod1_t p1a_d [NUM_AXES];
  prod1_t p1b_d [NUM_AXES];
  base_t  ov1_d [NUM_AXES];
  tvec_t  t2_d  [NUM_AXES];
  prod2_t wt3_d [NUM_AXES];
  prod2_t ca3_d [NUM_AXES];
  prod2_t cb3_d [NUM_AXES];
  rot_t   r4_d  [NUM_AXES];
  logic signed [CW-1:0] pos_d [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    localparam int J = (i + 1) % NUM_AXES;
    localparam int K = (i + 2) % NUM_AXES;

    logic signed [S1W-1:0] dif1;
    logic signed [S1W-1:0] sum1;
    logic signed [S2W-1:0] sum2;
    logic signed [FW-1:0]  fsum;

    // First cross product terms, q_j * v_k and q_k * v_j.
    assign p1a_d[i] = q_in[J] * v_in[K];
    assign p1b_d[i] = q_in[K] * v_in[J];
    assign ov1_d[i] = OW'(o_in[i]) + OW'(v_in[i]);

    // t = round(2 * (q x v)) with round-half-up.
    assign dif1   = S1W'(p1a_q[i]) - S1W'(p1b_q[i]);
    assign sum1   = (dif1 <<< 1) + S1W'(RND_HALF);
    assign t2_d[i] = sum1[S1W-1:FRAC_SHIFT];

    // Second stage terms w * t_i, q_j * t_k and q_k * t_j.
    assign wt3_d[i] = q2_q[3] * t2_q[i];
    assign ca3_d[i] = q2_q[J] * t2_q[K];
    assign cb3_d[i] = q2_q[K] * t2_q[J];

    assign sum2    = S2W'(wt3_q[i]) + S2W'(ca3_q[i]) - S2W'(cb3_q[i]) + S2W'(RND_HALF);
    assign r4_d[i] = sum2[S2W-1:FRAC_SHIFT];

    // Clamp to the signed 32-bit range when the upper bits disagree.
    assign fsum = FW'(ov4_q[i]) + FW'(r4_q[i]);
    always_comb begin
      if ((&fsum[FW-1:CW-1]) || !(|fsum[FW-1:CW-1])) begin
        pos_d[i] = fsum[CW-1:0];
      end else if (fsum[FW-1]) begin
        pos_d[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pos_d[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        p1a_q[a] <= p1a_d[a];
        p1b_q[a] <= p1b_d[a];
        ov1_q[a] <= ov1_d[a];
      end
      for (int c = 0; c < 4; c++) q1_q[c] <= q_in[c];
      sz1_q <= quad_size_in_i;
    end
    if (en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        t2_q[a]  <= t2_d[a];
        ov2_q[a] <= ov1_q[a];
      end
      for (int c = 0; c < 4; c++) q2_q[c] <= q1_q[c];
      sz2_q <= sz1_q;
    end
    if (en[2]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        wt3_q[a] <= wt3_d[a];
        ca3_q[a] <= ca3_d[a];
        cb3_q[a] <= cb3_d[a];
        ov3_q[a] <= ov2_q[a];
      end
      sz3_q <= sz2_q;
    end
    if (en[3]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        r4_q[a]  <= r4_d[a];
        ov4_q[a] <= ov3_q[a];
      end
      sz4_q <= sz3_q;
    end
    if (en[4]) begin
      for (int a = 0; a < NUM_AXES; a++) pos_q[a] <= pos_d[a];
      sz5_q <= sz4_q;
    end
  end

  assign pos_x_o         = pos_q[0];
  assign pos_y_o         = pos_q[1];
  assign pos_z_o         = pos_q[2];
  assign quad_size_out_o = sz5_q;

  // A full pipeline behind a stalled output must refuse new beats.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while every stage is full and stalled");

  // A valid beat in the first stage moves on whenever the next stage loads.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && en[1]) |=> vld_q[1])
    else $error("beat lost between the first and second stage");

  // A held fourth stage keeps its rounded rotation unchanged.
  a_hold_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !en[3]) |=> (vld_q[3] && $stable(r4_q[0]) && $stable(r4_q[1])
      && $stable(r4_q[2])))
    else $error("stalled stage changed its contents");

endmodule
